// ===== design/i2cm_pkg.sv =====
package i2cm_pkg;

	localparam int unsigned MaxBytes = 255;

	typedef enum logic [1:0] {
		OP_IDLE  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2,
		OP_BYTE  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		CFG_ADDR  = 2'd0,
		CFG_HOLD  = 2'd1,
		CFG_DELAY = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] byte_count;
		logic [7:0] write_byte;
		logic       scl_in;
		logic       sda_in;
	} tick_t;

	typedef struct packed {
		logic       scl_drive_low;
		logic       sda_drive_low;
		logic [7:0] read_byte;
		logic       read_valid;
		logic       byte_request;
		logic       busy_res;
		logic       done_res;
		logic       status;
		logic [7:0] bytes_done;
	} result_t;

	// classified command from the front part
	typedef struct packed {
		logic       start;
		logic       rd;
		logic       supply;
		logic [7:0] count;
		logic [7:0] wbyte;
		logic       scl;
		logic       sda;
	} cmd_t;

endpackage

// ===== design/i2cm_tick_if.sv =====
interface i2cm_tick_if import i2cm_pkg::*; ();
	logic  valid;
	logic  ready;
	tick_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== design/i2cm_result_if.sv =====
interface i2cm_result_if import i2cm_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== design/i2cm_front.sv =====
module i2cm_front import i2cm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  tick_t in_data,
	output logic in_ready,
	output logic cmd_valid,
	output cmd_t cmd_data,
	input  logic cmd_ready
);
	cmd_t cmd_s1;
	logic valid_s1;
	cmd_t next;

	always_comb begin
		next.start  = (in_data.opcode == OP_READ) || (in_data.opcode == OP_WRITE);
		next.rd     = (in_data.opcode == OP_READ);
		next.supply = (in_data.opcode == OP_BYTE);
		next.count  = (32'(in_data.byte_count) > MaxBytes) ? 8'(MaxBytes) : in_data.byte_count;
		next.wbyte  = in_data.write_byte;
		next.scl    = in_data.scl_in;
		next.sda    = in_data.sda_in;
	end

	assign in_ready  = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;
	assign cmd_data  = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1 <= next;
		end
	end
endmodule

// ===== design/i2cm_queue.sv =====
module i2cm_queue import i2cm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	input  cmd_t wr_data,
	output logic wr_ready,
	output logic rd_valid,
	output cmd_t rd_data,
	input  logic rd_ready
);
	cmd_t       slot_q [2];
	logic [1:0] cnt_q;
	logic       wp_q;
	logic       rp_q;
	logic       push;
	logic       pop;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = slot_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= wr_data;
	end
endmodule

// ===== design/i2cm_back.sv =====
module i2cm_back import i2cm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  addr_byte,
	input  logic [15:0] hold_ticks,
	input  logic [23:0] stop_delay,
	input  logic        cmd_valid,
	input  cmd_t        cmd_data,
	output logic        cmd_ready,
	output logic        res_valid,
	output result_t     res_data,
	input  logic        res_ready
);
	typedef enum logic [3:0] {
		PH_IDLE, PH_START_WAIT, PH_START_A, PH_START_B, PH_BIT_SETUP, PH_BIT_RISE,
		PH_BIT_HIGH, PH_WAIT_BYTE, PH_STOP_SETUP, PH_STOP_RISE, PH_STOP_DELAY,
		PH_STOP_WAIT, PH_STOP_HOLD
	} phase_t;

	phase_t      phase_q, ph_n;
	logic [3:0]  bit_q, bit_n;
	logic [7:0]  shift_q, shift_n;
	logic [15:0] hold_q, hold_n;
	logic [23:0] swait_q, swait_n;
	logic [7:0]  rem_q, rem_n;
	logic [7:0]  dcnt_q, dcnt_n;
	logic        rd_q, rd_n, scl_q, scl_n, sda_q, sda_n, addr_q, addr_n, nak_q, nak_n;
	logic        rvalid, done, elapsed, step;
	logic [15:0] hlen;
	logic [23:0] swinc;
	result_t     out_q;
	logic        oval_q;

	assign step      = cmd_valid && cmd_ready;
	assign cmd_ready = !oval_q || res_ready;
	assign res_valid = oval_q;
	assign res_data  = out_q;
	assign hlen      = (hold_ticks == 16'd0) ? 16'd1 : hold_ticks;
	assign elapsed   = ({1'b0, hold_q} + 17'd1) >= {1'b0, hlen};
	assign swinc     = swait_q + 24'd1;

	function automatic logic sampled(input logic a, input logic r, input logic [3:0] b);
		return (!a && r) ? (b < 4'd8) : (b == 4'd8);
	endfunction

	always_comb begin
		logic bidx_tmp;
		bidx_tmp = 1'b0;
		ph_n = phase_q; bit_n = bit_q; shift_n = shift_q; hold_n = hold_q;
		swait_n = swait_q; rem_n = rem_q; dcnt_n = dcnt_q; rd_n = rd_q;
		scl_n = scl_q; sda_n = sda_q; addr_n = addr_q; nak_n = nak_q;
		rvalid = 1'b0; done = 1'b0;
		// hold counter advance, cleared where elapsed
		if (phase_q == PH_START_A || phase_q == PH_START_B || phase_q == PH_BIT_SETUP
				|| phase_q == PH_BIT_HIGH || phase_q == PH_STOP_SETUP
				|| phase_q == PH_STOP_HOLD) begin
			hold_n = elapsed ? 16'd0 : hold_q + 16'd1;
		end
		unique case (phase_q)
			PH_IDLE: begin
				if (cmd_data.start) begin
					rd_n = cmd_data.rd; rem_n = cmd_data.count; dcnt_n = 8'd0;
					nak_n = 1'b0; addr_n = 1'b1; ph_n = PH_START_WAIT;
				end
			end
			PH_START_WAIT: if (cmd_data.sda) begin hold_n = 16'd0; ph_n = PH_START_A; end
			PH_START_A: if (elapsed) begin sda_n = 1'b1; ph_n = PH_START_B; end
			PH_START_B: begin
				if (elapsed) begin
					scl_n = 1'b1;
					shift_n = rd_q ? (addr_byte | 8'h01) : (addr_byte & 8'hFE);
					bit_n = 4'd0; bidx_tmp = 1'b1;
				end
			end
			PH_BIT_SETUP: if (elapsed) begin scl_n = 1'b0; ph_n = PH_BIT_RISE; end
			PH_BIT_RISE: begin
				if (cmd_data.scl) begin
					if (sampled(addr_q, rd_q, bit_q)) begin
						if (bit_q < 4'd8) begin
							shift_n = {shift_q[6:0], cmd_data.sda};
							if (bit_q == 4'd7) begin rvalid = 1'b1; dcnt_n = dcnt_q + 8'd1; end
						end else begin
							nak_n = cmd_data.sda;
						end
					end
					hold_n = 16'd0; ph_n = PH_BIT_HIGH;
				end
			end
			PH_BIT_HIGH: begin
				if (elapsed) begin
					scl_n = 1'b1;
					if (bit_q < 4'd8) begin
						bit_n = bit_q + 4'd1; bidx_tmp = 1'b1;
					end else begin
						if (!addr_q) begin
							if (!rd_q) dcnt_n = dcnt_q + 8'd1;
							if (rem_q != 8'd0) rem_n = rem_q - 8'd1;
						end
						addr_n = 1'b0;
						if (addr_q && nak_q) begin
							sda_n = 1'b1; hold_n = 16'd0; ph_n = PH_STOP_SETUP;
						end else begin
							nak_n = 1'b0;
							if (rem_n == 8'd0) begin
								sda_n = 1'b1; hold_n = 16'd0; ph_n = PH_STOP_SETUP;
							end else if (rd_q) begin
								shift_n = 8'd0; bit_n = 4'd0; bidx_tmp = 1'b1;
							end else begin
								ph_n = PH_WAIT_BYTE;
							end
						end
					end
				end
			end
			PH_WAIT_BYTE: begin
				if (cmd_data.supply) begin
					shift_n = cmd_data.wbyte; bit_n = 4'd0; bidx_tmp = 1'b1;
				end
			end
			PH_STOP_SETUP: if (elapsed) begin scl_n = 1'b0; ph_n = PH_STOP_RISE; end
			PH_STOP_RISE: begin
				if (cmd_data.scl) begin
					swait_n = 24'd0;
					if (stop_delay == 24'd0) begin sda_n = 1'b0; ph_n = PH_STOP_WAIT; end
					else ph_n = PH_STOP_DELAY;
				end
			end
			PH_STOP_DELAY: begin
				swait_n = swinc;
				if (swinc >= stop_delay) begin sda_n = 1'b0; ph_n = PH_STOP_WAIT; end
			end
			PH_STOP_WAIT: if (cmd_data.sda) begin hold_n = 16'd0; ph_n = PH_STOP_HOLD; end
			PH_STOP_HOLD: if (elapsed) begin ph_n = PH_IDLE; done = 1'b1; end
			default: ph_n = PH_IDLE;
		endcase
		// enter a bit slot using the updated bit index and shift byte
		if (bidx_tmp) begin
			if (sampled(addr_n, rd_n, bit_n)) sda_n = 1'b0;
			else if (bit_n < 4'd8) sda_n = !shift_n[3'(4'd7 - bit_n)];
			else sda_n = (rem_n != 8'd1);
			hold_n = 16'd0; ph_n = PH_BIT_SETUP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; bit_q <= '0; shift_q <= '0; hold_q <= '0; swait_q <= '0;
			rem_q <= '0; dcnt_q <= '0; rd_q <= 1'b0; scl_q <= 1'b0; sda_q <= 1'b0;
			addr_q <= 1'b0; nak_q <= 1'b0; oval_q <= 1'b0;
		end else begin
			if (res_ready) oval_q <= 1'b0;
			if (step) begin
				phase_q <= ph_n; bit_q <= bit_n; shift_q <= shift_n; hold_q <= hold_n;
				swait_q <= swait_n; rem_q <= rem_n; dcnt_q <= dcnt_n; rd_q <= rd_n;
				scl_q <= scl_n; sda_q <= sda_n; addr_q <= addr_n; nak_q <= nak_n;
				oval_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q.scl_drive_low <= scl_n;
			out_q.sda_drive_low <= sda_n;
			out_q.read_byte     <= rvalid ? shift_n : 8'd0;
			out_q.read_valid    <= rvalid;
			out_q.byte_request  <= ph_n == PH_WAIT_BYTE;
			out_q.busy_res      <= ph_n != PH_IDLE;
			out_q.done_res      <= done;
			out_q.status        <= done && nak_n;
			out_q.bytes_done    <= dcnt_n;
		end
	end
endmodule

// ===== design/i2c_master_transfer_engine.sv =====
// A tick passes the front register, a two-entry queue that absorbs stalls, and the back
// output register. Throughput: one tick per cycle while out_result.ready is high.
// The back part's bus sequencer updates once per tick, so line timing follows the ticks.
// Reset (arst_n low, asynchronous): sequencer idle, lines released, queue empty,
// slave_address_byte 0, hold_ticks 500, stop_delay_ticks 50000.
module i2c_master_transfer_engine import i2cm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	i2cm_tick_if.sink     in_tick,
	i2cm_result_if.source out_result,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [23:0]   cfg_data
);
	logic [7:0]  addr_q;
	logic [15:0] hold_q;
	logic [23:0] delay_q;
	logic        f_valid, f_ready, b_valid, b_ready;
	cmd_t        f_data, b_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= 8'd0;
			hold_q  <= 16'd500;
			delay_q <= 24'd50000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ADDR:  addr_q  <= cfg_data[7:0];
				CFG_HOLD:  hold_q  <= cfg_data[15:0];
				CFG_DELAY: delay_q <= cfg_data;
				default: ;
			endcase
		end
	end

	i2cm_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_tick.valid), .in_data(in_tick.data), .in_ready(in_tick.ready),
		.cmd_valid(f_valid), .cmd_data(f_data), .cmd_ready(f_ready)
	);

	i2cm_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_data(f_data), .wr_ready(f_ready),
		.rd_valid(b_valid), .rd_data(b_data), .rd_ready(b_ready)
	);

	i2cm_back u_back (
		.clk(clk), .arst_n(arst_n),
		.addr_byte(addr_q), .hold_ticks(hold_q), .stop_delay(delay_q),
		.cmd_valid(b_valid), .cmd_data(b_data), .cmd_ready(b_ready),
		.res_valid(out_result.valid), .res_data(out_result.data),
		.res_ready(out_result.ready)
	);

	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_result.valid && out_result.data.status |-> out_result.data.done_res)
		else $error("status without done");
	a_read_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_result.valid && out_result.data.read_valid |-> out_result.data.busy_res)
		else $error("read byte outside transfer");
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_result.valid && out_result.data.byte_request |-> out_result.data.busy_res)
		else $error("byte request while idle");
endmodule

// ===== tb/tb_i2cm_channels.sv =====
`timescale 1ns / 100ps

// Channels already provided by the design: i2cm_tick_if and i2cm_result_if.
// This file holds the driver-side helper types shared by the testbench.
package tb_i2cm_pkg;
	import i2cm_pkg::*;

	typedef struct {
		opcode_t    op;
		logic [7:0] count;
		logic [7:0] wbyte;
		logic       scl;
		logic       sda;
		logic       has_exp;
		result_t    exp;
	} stim_row_t;
endpackage

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import i2cm_pkg::*;
	import tb_i2cm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_START_WAIT, S_START_A, S_START_B, S_BIT_SETUP, S_BIT_RISE, S_BIT_HIGH,
		S_WAIT_BYTE, S_STOP_SETUP, S_STOP_RISE, S_STOP_DELAY, S_STOP_WAIT, S_STOP_HOLD
	} bus_phase_t;

	localparam int WatchdogLimit = 20000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = 0;
	logic [23:0] cfg_data = 0;

	i2cm_tick_if   in_tick();
	i2cm_result_if out_result();

	i2c_master_transfer_engine u_dut (
		.clk(clk), .arst_n(arst_n), .in_tick(in_tick), .out_result(out_result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// engine mirror
	logic [7:0]  m_addr;
	logic [15:0] m_hold;
	logic [23:0] m_delay;
	bus_phase_t  m_phase;
	logic [3:0]  m_bit;
	logic [7:0]  m_shift, m_remaining, m_done_count;
	logic [15:0] m_hold_count;
	logic [23:0] m_stop_count;
	logic        m_is_read, m_scl_low, m_sda_low, m_addr_phase, m_nak;

	result_t     pending_results[$];
	int          error_count = 0;
	int          idle_cycles = 0;
	bit          no_stall = 0;
	bit          drive_busy;
	logic        bus_scl = 1, bus_sda = 1;
	logic        row_has_exp = 0;
	result_t     row_exp;

	function automatic bit hold_done();
		logic [16:0] len;
		len = (m_hold == 16'd0) ? 17'd1 : {1'b0, m_hold};
		if ({1'b0, m_hold_count} + 17'd1 >= len) begin
			m_hold_count = 16'd0;
			return 1;
		end
		m_hold_count++;
		return 0;
	endfunction

	function automatic bit sampled_bit();
		if (!m_addr_phase && m_is_read) return m_bit < 8;
		return m_bit == 8;
	endfunction

	function automatic void begin_bit();
		if (sampled_bit()) m_sda_low = 1'b0;
		else if (m_bit < 8) m_sda_low = ~m_shift[7 - m_bit];
		else m_sda_low = (m_remaining == 8'd1) ? 1'b0 : 1'b1;
		m_hold_count = 16'd0;
		m_phase = S_BIT_SETUP;
	endfunction

	function automatic void begin_stop();
		m_sda_low = 1'b1;
		m_hold_count = 16'd0;
		m_phase = S_STOP_SETUP;
	endfunction

	function automatic void advance_byte();
		if (m_remaining == 8'd0) begin_stop();
		else if (m_is_read) begin
			m_shift = 8'd0;
			m_bit = 4'd0;
			begin_bit();
		end else m_phase = S_WAIT_BYTE;
	endfunction

	function automatic void mirror_reset();
		m_addr = 8'd0; m_hold = 16'd500; m_delay = 24'd50000;
		m_phase = S_IDLE; m_bit = 4'd0; m_shift = 8'd0; m_hold_count = 16'd0;
		m_stop_count = 24'd0; m_remaining = 8'd0; m_done_count = 8'd0; m_is_read = 1'b0;
		m_scl_low = 1'b0; m_sda_low = 1'b0; m_addr_phase = 1'b0; m_nak = 1'b0;
	endfunction

	function automatic result_t predict_tick(tick_t t);
		result_t r;
		logic rvalid, done;
		rvalid = 0;
		done = 0;
		case (m_phase)
			S_IDLE: begin
				if (t.opcode == OP_READ || t.opcode == OP_WRITE) begin
					m_is_read = (t.opcode == OP_READ);
					m_remaining = t.byte_count;
					m_done_count = 8'd0; m_nak = 1'b0; m_addr_phase = 1'b1;
					m_phase = S_START_WAIT;
				end
			end
			S_START_WAIT: if (t.sda_in) begin
				m_hold_count = 16'd0;
				m_phase = S_START_A;
			end
			S_START_A: if (hold_done()) begin
				m_sda_low = 1'b1;
				m_phase = S_START_B;
			end
			S_START_B: if (hold_done()) begin
				m_scl_low = 1'b1;
				m_shift = m_is_read ? (m_addr | 8'h01) : (m_addr & 8'hFE);
				m_bit = 4'd0;
				begin_bit();
			end
			S_BIT_SETUP: if (hold_done()) begin
				m_scl_low = 1'b0;
				m_phase = S_BIT_RISE;
			end
			S_BIT_RISE: if (t.scl_in) begin
				if (sampled_bit()) begin
					if (m_bit < 8) begin
						m_shift = {m_shift[6:0], t.sda_in};
						if (m_bit == 7) begin
							rvalid = 1;
							m_done_count++;
						end
					end else m_nak = t.sda_in;
				end
				m_hold_count = 16'd0;
				m_phase = S_BIT_HIGH;
			end
			S_BIT_HIGH: if (hold_done()) begin
				m_scl_low = 1'b1;
				if (m_bit < 8) begin
					m_bit++;
					begin_bit();
				end else if (m_addr_phase) begin
					m_addr_phase = 1'b0;
					if (m_nak) begin_stop();
					else advance_byte();
				end else begin
					if (!m_is_read) m_done_count++;
					m_nak = 1'b0;
					if (m_remaining != 8'd0) m_remaining--;
					advance_byte();
				end
			end
			S_WAIT_BYTE: if (t.opcode == OP_BYTE) begin
				m_shift = t.write_byte;
				m_bit = 4'd0;
				begin_bit();
			end
			S_STOP_SETUP: if (hold_done()) begin
				m_scl_low = 1'b0;
				m_phase = S_STOP_RISE;
			end
			S_STOP_RISE: if (t.scl_in) begin
				m_stop_count = 24'd0;
				if (m_delay == 24'd0) begin
					m_sda_low = 1'b0;
					m_phase = S_STOP_WAIT;
				end else m_phase = S_STOP_DELAY;
			end
			S_STOP_DELAY: begin
				m_stop_count++;
				if (m_stop_count >= m_delay) begin
					m_sda_low = 1'b0;
					m_phase = S_STOP_WAIT;
				end
			end
			S_STOP_WAIT: if (t.sda_in) begin
				m_hold_count = 16'd0;
				m_phase = S_STOP_HOLD;
			end
			S_STOP_HOLD: if (hold_done()) begin
				m_phase = S_IDLE;
				done = 1;
			end
			default: m_phase = S_IDLE;
		endcase
		r.scl_drive_low = m_scl_low;
		r.sda_drive_low = m_sda_low;
		r.read_byte     = rvalid ? m_shift : 8'h00;
		r.read_valid    = rvalid;
		r.byte_request  = (m_phase == S_WAIT_BYTE);
		r.busy_res      = (m_phase != S_IDLE);
		r.done_res      = done;
		r.status        = done ? m_nak : 1'b0;
		r.bytes_done    = m_done_count;
		return r;
	endfunction

	// acceptance and checking at the rising edge
	always @(posedge clk) begin
		result_t exp_r;
		logic    moved;
		if (arst_n) begin
			moved = (in_tick.valid && in_tick.ready) || (out_result.valid && out_result.ready);
			idle_cycles <= moved ? 0 : idle_cycles + 1;
			if (in_tick.valid && in_tick.ready) begin
				exp_r = predict_tick(in_tick.data);
				if (drive_busy && row_has_exp) exp_r = row_exp;
				pending_results.push_back(exp_r);
			end
			if (out_result.valid && out_result.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_result.data);
					error_count++;
				end else begin
					exp_r = pending_results.pop_front();
					if (out_result.data !== exp_r) begin
						$display("%0t: mismatch expected %p actual %p", $time, exp_r,
							out_result.data);
						error_count++;
					end
				end
			end
			if (idle_cycles >= WatchdogLimit) begin
				$display("testbench: errors");
				$finish;
			end
		end
	end

	// receiver stalls
	initial begin
		out_result.ready = 0;
		forever begin
			@(negedge clk);
			out_result.ready <= no_stall || ($urandom_range(99) >= 35);
		end
	end

	// Slave model: bus lines follow the master drives, with random stretching
	// and random ACK/data. Only used for sampled line values in random items.
	function automatic void bus_lines(output logic scl, output logic sda);
		scl = m_scl_low ? 1'b0 : ($urandom_range(9) != 0);
		sda = m_sda_low ? 1'b0 : ($urandom_range(5) != 0 ? 1'($urandom_range(1)) : 1'b1);
	endfunction

	task automatic send_tick(opcode_t op, logic [7:0] cnt, logic [7:0] wb, logic scl,
		logic sda);
		bit acc;
		// randomly idle the channel before presenting the transaction, unless no_stall is set
		while (!no_stall && $urandom_range(99) < 35) begin
			in_tick.valid <= 0;
			@(negedge clk);
		end
		in_tick.data  <= '{opcode: op, byte_count: cnt, write_byte: wb, scl_in: scl,
			sda_in: sda};
		in_tick.valid <= 1;
		// ready comes from registers only, so it is stable between edges
		forever begin
			acc = in_tick.ready;
			@(posedge clk);
			if (acc) break;
			@(negedge clk);
		end
		@(negedge clk);
	endtask

	task automatic write_cfg(cfg_index_t idx, logic [23:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		case (idx)
			CFG_ADDR:  m_addr = val[7:0];
			CFG_HOLD:  m_hold = val[15:0];
			CFG_DELAY: m_delay = val;
			default: ;
		endcase
	endtask

	task automatic drain();
		in_tick.valid <= 0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// a slice of a transfer with well-formed slave behavior plus noise
	task automatic run_transfer(bit rd, logic [7:0] cnt);
		opcode_t op;
		logic scl, sda;
		int guard;
		op = rd ? OP_READ : OP_WRITE;
		send_tick(op, cnt, 8'($urandom), 1'b1, 1'b1);
		guard = 0;
		while (m_phase != S_IDLE && guard < 45) begin
			bus_lines(scl, sda);
			if (m_phase == S_WAIT_BYTE && $urandom_range(3) != 0)
				send_tick(OP_BYTE, 8'($urandom), 8'($urandom), scl, sda);
			else
				send_tick(opcode_t'($urandom_range(3)), 8'($urandom), 8'($urandom), scl,
					sda);
			guard++;
		end
	endtask

	stim_row_t rows[$];
	initial begin
		stim_row_t r;
		result_t   idle_r;
		in_tick.valid = 0;
		in_tick.data = '0;
		drive_busy = 0;
		mirror_reset();
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: idle ticks after reset, ignored opcodes, then transfers at extremes
		idle_r = '0;
		r = '{op: OP_IDLE, count: 8'hFF, wbyte: 8'hFF, scl: 1, sda: 1, has_exp: 1, exp: idle_r};
		rows.push_back(r);
		r.op = OP_BYTE;
		rows.push_back(r);
		r = '{op: OP_IDLE, count: 0, wbyte: 0, scl: 0, sda: 0, has_exp: 1, exp: idle_r};
		rows.push_back(r);
		drive_busy = 1;
		foreach (rows[i]) begin
			row_has_exp = rows[i].has_exp;
			row_exp = rows[i].exp;
			send_tick(rows[i].op, rows[i].count, rows[i].wbyte, rows[i].scl, rows[i].sda);
		end
		drive_busy = 0;
		row_has_exp = 0;
		drain();

		write_cfg(CFG_HOLD, 24'd1);
		write_cfg(CFG_DELAY, 24'd0);
		write_cfg(CFG_ADDR, 24'hFF);
		run_transfer(1, 8'd0);
		run_transfer(0, 8'd2);
		run_transfer(1, 8'd3);
		drain();
		write_cfg(CFG_ADDR, 24'h00);
		write_cfg(CFG_HOLD, 24'd0);
		write_cfg(CFG_DELAY, 24'd3);
		run_transfer(0, 8'd1);
		run_transfer(1, 8'd1);
		drain();

		// random phases with several settings
		for (int ph = 0; ph < 6; ph++) begin
			write_cfg(CFG_ADDR, 24'($urandom));
			write_cfg(CFG_HOLD, (ph == 5) ? 24'hFFFF : 24'($urandom_range(3)));
			write_cfg(CFG_DELAY, (ph == 4) ? 24'hFFFFFF : 24'($urandom_range(4)));
			no_stall = (ph == 2);
			if (ph == 5) begin
				// largest hold: only a bounded slice of one transfer
				for (int k = 0; k < 40; k++) begin
					logic scl, sda;
					bus_lines(scl, sda);
					send_tick(k == 0 ? OP_WRITE : OP_IDLE, 8'd1, 8'd0, scl, sda);
				end
				drain();
			end else begin
				for (int k = 0; k < 6; k++) begin
					run_transfer(1'($urandom_range(1)),
						(k == 5) ? 8'hFF : 8'($urandom_range(4)));
					if (ph == 4) break;
				end
				drain();
			end
		end
		drain();
		if (error_count == 0) $display("testbench: clean");
		else $display("testbench: errors");
		$finish;
	end
endmodule
